// ===== rtl/sa38_pkg.sv =====
// Shared widths, codes, types and function tables for the split 38-bit adder ALU.
`timescale 1ns / 1ps

package sa38_pkg;

  localparam int WordW  = 36;
  localparam int MainW  = 38;
  localparam int AddrW  = 23;
  localparam int FuncW  = 5;
  localparam int ASelW  = 3;
  localparam int BSelW  = 2;
  localparam int CarryW = 4;
  localparam int HalfW  = 18;

  localparam logic [MainW-1:0] Mask36 = 38'o0777777777777;
  localparam logic [MainW-1:0] Mask38 = 38'o3777777777777;
  localparam logic [MainW:0]   Bit18  = 39'o1000000;

  localparam logic [15:0] Cry1Table = 16'h9966;
  localparam logic [7:0]  OvfTable  = 8'h7E;

  // func fields
  localparam int FuncBoolBit = 4;

  // carry_ctl bits
  localparam int CcAdxCin = 0;
  localparam int CcLong   = 1;
  localparam int CcInh18  = 2;
  localparam int CcGen18  = 3;

  // a_source codes; any code with ASelZeroBit set selects zero
  localparam logic [ASelW-1:0] ASEL_AR   = 3'd0;
  localparam logic [ASelW-1:0] ASEL_ARX  = 3'd1;
  localparam logic [ASelW-1:0] ASEL_MQ   = 3'd2;
  localparam logic [ASelW-1:0] ASEL_HELD = 3'd3;
  localparam int ASelZeroBit = 2;

  // b_source codes
  localparam logic [BSelW-1:0] BSEL_FAST   = 2'd0;
  localparam logic [BSelW-1:0] BSEL_BR_SH1 = 2'd1;
  localparam logic [BSelW-1:0] BSEL_BR     = 2'd2;
  localparam logic [BSelW-1:0] BSEL_AR_SH2 = 2'd3;

  // operation codes, named after their Boolean-mode meaning
  typedef enum logic [3:0] {
    OP_NOT_A    = 4'd0,
    OP_NAND     = 4'd1,
    OP_NA_OR_B  = 4'd2,
    OP_ONES     = 4'd3,
    OP_NOR      = 4'd4,
    OP_NOT_B    = 4'd5,
    OP_XNOR     = 4'd6,
    OP_A_OR_NB  = 4'd7,
    OP_NA_AND_B = 4'd8,
    OP_XOR      = 4'd9,
    OP_B        = 4'd10,
    OP_OR       = 4'd11,
    OP_ZERO     = 4'd12,
    OP_A_AND_NB = 4'd13,
    OP_AND      = 4'd14,
    OP_A        = 4'd15
  } op_t;

  typedef struct packed {
    logic [WordW-1:0]  acc_word;
    logic [WordW-1:0]  acc_ext_word;
    logic [WordW-1:0]  buf_word;
    logic [WordW-1:0]  buf_ext_word;
    logic [WordW-1:0]  quotient_word;
    logic [WordW-1:0]  fast_reg_word;
    logic [AddrW-1:0]  held_or_pc;
    logic [FuncW-1:0]  func;
    logic [ASelW-1:0]  a_source;
    logic [BSelW-1:0]  b_source;
    logic [CarryW-1:0] carry_ctl;
  } operand_t;

  typedef struct packed {
    logic [WordW-1:0] low_a;
    logic [WordW-1:0] low_b;
    logic [MainW-1:0] main_a;
    logic [MainW-1:0] main_b;
  } opnd_t;

  typedef struct packed {
    logic [MainW-1:0] main_sum;
    logic [WordW-1:0] low_sum;
    logic             carry_minus_two;
    logic             carry_one;
    logic             overflow_flag;
    logic             low_carry_out;
  } result_t;

  typedef struct packed {
    logic [MainW-1:0] x;
    logic [MainW-1:0] y;
  } pair_t;

  function automatic logic [MainW-1:0] boole(op_t op, logic [MainW-1:0] a,
                                             logic [MainW-1:0] b, logic [MainW-1:0] m);
    logic [MainW-1:0] na;
    logic [MainW-1:0] nb;
    na = ~a & m;
    nb = ~b & m;
    case (op)
      OP_NOT_A:    boole = na;
      OP_NAND:     boole = na | nb;
      OP_NA_OR_B:  boole = na | b;
      OP_ONES:     boole = m;
      OP_NOR:      boole = na & nb;
      OP_NOT_B:    boole = nb;
      OP_XNOR:     boole = a ^ nb;
      OP_A_OR_NB:  boole = a | nb;
      OP_NA_AND_B: boole = na & b;
      OP_XOR:      boole = a ^ b;
      OP_B:        boole = b;
      OP_OR:       boole = a | b;
      OP_ZERO:     boole = '0;
      OP_A_AND_NB: boole = a & nb;
      OP_AND:      boole = a & b;
      default:     boole = a;
    endcase
  endfunction

  // addend pair for arithmetic mode; the sum is x + y + carry in
  function automatic pair_t arith_pair(op_t op, logic [MainW-1:0] a,
                                       logic [MainW-1:0] b, logic [MainW-1:0] m);
    logic [MainW-1:0] nb;
    pair_t p;
    nb = ~b & m;
    case (op)
      OP_NOT_A:    begin p.x = a;      p.y = '0;     end
      OP_NAND:     begin p.x = a;      p.y = a & nb; end
      OP_NA_OR_B:  begin p.x = a;      p.y = a & b;  end
      OP_ONES:     begin p.x = a;      p.y = a;      end
      OP_NOR:      begin p.x = a | b;  p.y = '0;     end
      OP_NOT_B:    begin p.x = a | b;  p.y = a & nb; end
      OP_XNOR:     begin p.x = a;      p.y = b;      end
      OP_A_OR_NB:  begin p.x = a;      p.y = a | b;  end
      OP_NA_AND_B: begin p.x = a | nb; p.y = '0;     end
      OP_XOR:      begin p.x = a;      p.y = nb;     end
      OP_B:        begin p.x = a | b;  p.y = a & b;  end
      OP_OR:       begin p.x = a;      p.y = a | nb; end
      OP_ZERO:     begin p.x = '0;     p.y = m;      end
      OP_A_AND_NB: begin p.x = a & nb; p.y = m;      end
      OP_AND:      begin p.x = a & b;  p.y = m;      end
      default:     begin p.x = a;      p.y = m;      end
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/sa38_operand_if.sv =====
// Valid/ready channel carrying one operand set into the ALU.
`timescale 1ns / 1ps

interface sa38_operand_if;
  logic                          valid;
  logic                          ready;
  logic [sa38_pkg::WordW-1:0]    acc_word;
  logic [sa38_pkg::WordW-1:0]    acc_ext_word;
  logic [sa38_pkg::WordW-1:0]    buf_word;
  logic [sa38_pkg::WordW-1:0]    buf_ext_word;
  logic [sa38_pkg::WordW-1:0]    quotient_word;
  logic [sa38_pkg::WordW-1:0]    fast_reg_word;
  logic [sa38_pkg::AddrW-1:0]    held_or_pc;
  logic [sa38_pkg::FuncW-1:0]    func;
  logic [sa38_pkg::ASelW-1:0]    a_source;
  logic [sa38_pkg::BSelW-1:0]    b_source;
  logic [sa38_pkg::CarryW-1:0]   carry_ctl;

  modport source (
    output valid, acc_word, acc_ext_word, buf_word, buf_ext_word, quotient_word,
           fast_reg_word, held_or_pc, func, a_source, b_source, carry_ctl,
    input  ready
  );
  modport sink (
    input  valid, acc_word, acc_ext_word, buf_word, buf_ext_word, quotient_word,
           fast_reg_word, held_or_pc, func, a_source, b_source, carry_ctl,
    output ready
  );
endinterface

// ===== rtl/sa38_result_if.sv =====
// Valid/ready channel carrying one ALU result out of the block.
`timescale 1ns / 1ps

interface sa38_result_if;
  logic                        valid;
  logic                        ready;
  logic [sa38_pkg::MainW-1:0]  main_sum;
  logic [sa38_pkg::WordW-1:0]  low_sum;
  logic                        carry_minus_two;
  logic                        carry_one;
  logic                        overflow_flag;
  logic                        low_carry_out;

  modport source (
    output valid, main_sum, low_sum, carry_minus_two, carry_one, overflow_flag,
           low_carry_out,
    input  ready
  );
  modport sink (
    input  valid, main_sum, low_sum, carry_minus_two, carry_one, overflow_flag,
           low_carry_out,
    output ready
  );
endinterface

// ===== rtl/sa38_opnd_mux.sv =====
// A and B source selection for the low (ADX) and main (AD) adders.
`timescale 1ns / 1ps

module sa38_opnd_mux (
  input  sa38_pkg::operand_t opr,
  output sa38_pkg::opnd_t    opnd
);

  function automatic logic [sa38_pkg::MainW-1:0] ext38(logic [sa38_pkg::WordW-1:0] w);
    return {{(sa38_pkg::MainW - sa38_pkg::WordW){w[sa38_pkg::WordW-1]}}, w};
  endfunction

  always_comb begin
    opnd.low_a = opr.a_source[sa38_pkg::ASelZeroBit] ? '0 : opr.acc_ext_word;

    case (opr.b_source)
      sa38_pkg::BSEL_FAST:   opnd.low_b = '1;
      sa38_pkg::BSEL_BR_SH1: opnd.low_b = {opr.buf_ext_word[sa38_pkg::WordW-2:0], 1'b0};
      sa38_pkg::BSEL_BR:     opnd.low_b = opr.buf_ext_word;
      default:               opnd.low_b = {opr.acc_ext_word[sa38_pkg::WordW-3:0], 2'b00};
    endcase

    case (opr.a_source)
      sa38_pkg::ASEL_AR:   opnd.main_a = ext38(opr.acc_word);
      sa38_pkg::ASEL_ARX:  opnd.main_a = ext38(opr.acc_ext_word);
      sa38_pkg::ASEL_MQ:   opnd.main_a = ext38(opr.quotient_word);
      sa38_pkg::ASEL_HELD: opnd.main_a = {{(sa38_pkg::MainW - sa38_pkg::AddrW){1'b0}},
                                          opr.held_or_pc};
      default:             opnd.main_a = '0;
    endcase

    // shifted forms fill from the top of BRX / ARX
    case (opr.b_source)
      sa38_pkg::BSEL_FAST:   opnd.main_b = ext38(opr.fast_reg_word);
      sa38_pkg::BSEL_BR_SH1: opnd.main_b = {opr.buf_word[sa38_pkg::WordW-1], opr.buf_word,
                                            opr.buf_ext_word[sa38_pkg::WordW-1]};
      sa38_pkg::BSEL_BR:     opnd.main_b = ext38(opr.buf_word);
      default:               opnd.main_b = {opr.acc_word,
                                            opr.acc_ext_word[sa38_pkg::WordW-1 -: 2]};
    endcase
  end

endmodule

// ===== rtl/sa38_alu.sv =====
// Function unit and adders: ADX, AD with carry-18 controls, and flag tables.
`timescale 1ns / 1ps

module sa38_alu (
  input  sa38_pkg::opnd_t               opnd,
  input  logic [sa38_pkg::FuncW-1:0]    func,
  input  logic [sa38_pkg::CarryW-1:0]   carry_ctl,
  output sa38_pkg::result_t             res
);

  localparam int MainW = sa38_pkg::MainW;
  localparam int WordW = sa38_pkg::WordW;
  localparam int HalfW = sa38_pkg::HalfW;

  sa38_pkg::op_t   op;
  logic            bool_mode;
  sa38_pkg::pair_t low_pair;
  sa38_pkg::pair_t main_pair;
  logic [MainW-1:0] low_a_ext;
  logic [MainW-1:0] low_b_ext;
  logic [MainW-1:0] low_bool;
  logic [MainW-1:0] main_bool;
  logic [WordW:0]   low_raw;
  logic             main_cin;
  logic [HalfW:0]   main_lo;
  logic [MainW-HalfW:0] main_hi;
  logic [MainW:0]   main_add;
  logic [MainW:0]   main_raw;

  assign op        = sa38_pkg::op_t'(func[3:0]);
  assign bool_mode = func[sa38_pkg::FuncBoolBit];
  assign low_a_ext = {{(MainW - WordW){1'b0}}, opnd.low_a};
  assign low_b_ext = {{(MainW - WordW){1'b0}}, opnd.low_b};

  always_comb begin
    low_pair  = sa38_pkg::arith_pair(op, low_a_ext, low_b_ext, sa38_pkg::Mask36);
    low_bool  = sa38_pkg::boole(op, low_a_ext, low_b_ext, sa38_pkg::Mask36);
    main_pair = sa38_pkg::arith_pair(op, opnd.main_a, opnd.main_b, sa38_pkg::Mask38);
    main_bool = sa38_pkg::boole(op, opnd.main_a, opnd.main_b, sa38_pkg::Mask38);

    if (bool_mode) begin
      low_raw = {1'b0, low_bool[WordW-1:0]};
    end else begin
      low_raw = {1'b0, low_pair.x[WordW-1:0]} + {1'b0, low_pair.y[WordW-1:0]}
              + {{WordW{1'b0}}, carry_ctl[sa38_pkg::CcAdxCin]};
    end

    // long chain: ADX carry-out feeds AD
    main_cin = low_raw[WordW] & carry_ctl[sa38_pkg::CcLong];

    main_lo = {1'b0, main_pair.x[HalfW-1:0]} + {1'b0, main_pair.y[HalfW-1:0]}
            + {{HalfW{1'b0}}, main_cin};
    main_hi = {1'b0, main_pair.x[MainW-1:HalfW]} + {1'b0, main_pair.y[MainW-1:HalfW]}
            + {{(MainW-HalfW){1'b0}}, main_lo[HalfW] & ~carry_ctl[sa38_pkg::CcInh18]};
    main_add = {main_hi, main_lo[HalfW-1:0]};

    if (bool_mode) begin
      main_raw = {1'b0, main_bool};
    end else if (carry_ctl[sa38_pkg::CcGen18]) begin
      main_raw = main_add + sa38_pkg::Bit18;
    end else begin
      main_raw = main_add;
    end

    res.main_sum        = main_raw[MainW-1:0];
    res.low_sum         = low_raw[WordW-1:0];
    res.carry_minus_two = main_raw[MainW];
    res.carry_one       = sa38_pkg::Cry1Table[main_raw[MainW -: 4]];
    res.overflow_flag   = sa38_pkg::OvfTable[main_raw[MainW-1 -: 3]];
    res.low_carry_out   = low_raw[WordW];
  end

endmodule

// ===== rtl/split_adder_alu_38_bit_unit.sv =====
// Top level of the split 38-bit adder ALU: input register, ALU logic, result register.
`timescale 1ns / 1ps

// Split double ALU in the 10181 style: a 36-bit low adder (ADX) and a 38-bit
// sign-extended main adder (AD) share one 5-bit function code, with carry
// controls for ADX carry-in, long chaining of the ADX carry into AD, and
// inhibiting or forcing the carry into bit 18. One operand set is taken per
// cycle while input ready is high; each result passes through the operand
// register and then the result register, moving on when the result side is
// ready. While a finished result waits, the operand register still takes one
// transfer if it is empty; once both registers hold items, input ready stays
// low until the result side takes its transfer.

module split_adder_alu_38_bit_unit (
  input logic                clk,
  input logic                rst,
  sa38_operand_if.sink       operands,
  sa38_result_if.source      results
);

  sa38_pkg::operand_t opr;
  logic               opr_valid;
  sa38_pkg::opnd_t    opnd;
  sa38_pkg::result_t  alu_res;
  sa38_pkg::result_t  res;
  logic               res_valid;
  logic               res_ready;
  logic               opr_ready;

  assign res_ready      = !res_valid || results.ready;
  assign opr_ready      = !opr_valid || res_ready;
  assign operands.ready = opr_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      opr_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (opr_ready) opr_valid <= operands.valid;
      if (res_ready) res_valid <= opr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (operands.valid && opr_ready) begin
      opr.acc_word      <= operands.acc_word;
      opr.acc_ext_word  <= operands.acc_ext_word;
      opr.buf_word      <= operands.buf_word;
      opr.buf_ext_word  <= operands.buf_ext_word;
      opr.quotient_word <= operands.quotient_word;
      opr.fast_reg_word <= operands.fast_reg_word;
      opr.held_or_pc    <= operands.held_or_pc;
      opr.func          <= operands.func;
      opr.a_source      <= operands.a_source;
      opr.b_source      <= operands.b_source;
      opr.carry_ctl     <= operands.carry_ctl;
    end
    if (opr_valid && res_ready) begin
      res <= alu_res;
    end
  end

  sa38_opnd_mux u_opnd_mux (
    .opr  (opr),
    .opnd (opnd)
  );

  sa38_alu u_alu (
    .opnd      (opnd),
    .func      (opr.func),
    .carry_ctl (opr.carry_ctl),
    .res       (alu_res)
  );

  assign results.valid           = res_valid;
  assign results.main_sum        = res.main_sum;
  assign results.low_sum         = res.low_sum;
  assign results.carry_minus_two = res.carry_minus_two;
  assign results.carry_one       = res.carry_one;
  assign results.overflow_flag   = res.overflow_flag;
  assign results.low_carry_out   = res.low_carry_out;

endmodule

// ===== rtl/sa38_checker.sv =====
// Port-level assertions for the split 38-bit adder ALU, bound to the top level.
`timescale 1ns / 1ps

module sa38_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sa38_pkg::MainW-1:0]  main_sum,
  input logic [sa38_pkg::WordW-1:0]  low_sum,
  input logic                        carry_minus_two,
  input logic                        carry_one,
  input logic                        overflow_flag
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped before transfer");

  // a held result keeps its main and low sums
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(main_sum) && $stable(low_sum))
    else $error("result payload changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // an accepted item is offered at the output in the cycle after the result side shows ready
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the result register");

  // flags follow the delivered sum through the carry and overflow tables
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      carry_one == sa38_pkg::Cry1Table[{carry_minus_two, main_sum[sa38_pkg::MainW-1 -: 3]}]
      && overflow_flag == sa38_pkg::OvfTable[main_sum[sa38_pkg::MainW-1 -: 3]])
    else $error("carry or overflow flag inconsistent with sum");

endmodule

bind split_adder_alu_38_bit_unit sa38_checker u_sa38_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (operands.valid),
  .in_ready        (operands.ready),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .main_sum        (results.main_sum),
  .low_sum         (results.low_sum),
  .carry_minus_two (results.carry_minus_two),
  .carry_one       (results.carry_one),
  .overflow_flag   (results.overflow_flag)
);

// ===== sim/split_adder_alu_38_bit_unit_test.sv =====
// Self-checking testbench for the split 38-bit adder ALU, directed table then random operands.
`timescale 1ns / 1ps

module split_adder_alu_38_bit_unit_test;

  localparam int OperandCount = 950;
  localparam int CycleLimit   = 200000;
  localparam int MaxIdle      = 16;

  localparam int WordW  = sa38_pkg::WordW;
  localparam int MainW  = sa38_pkg::MainW;
  localparam int AddrW  = sa38_pkg::AddrW;
  localparam int FuncW  = sa38_pkg::FuncW;
  localparam int ASelW  = sa38_pkg::ASelW;
  localparam int BSelW  = sa38_pkg::BSelW;
  localparam int CarryW = sa38_pkg::CarryW;

  localparam logic [63:0] Ones36  = 64'o777777777777;
  localparam logic [63:0] Ones38  = 64'o3777777777777;
  localparam logic [63:0] Upper20 = 64'o3777777000000;
  localparam logic [63:0] Low18   = 64'o777777;
  localparam logic [63:0] Carry18 = 64'o1000000;

  localparam logic [WordW-1:0] WordOnes   = {WordW{1'b1}};
  localparam logic [WordW-1:0] WordSign   = 36'o400000000000;
  localparam logic [WordW-1:0] WordMaxPos = 36'o377777777777;
  localparam logic [MainW-1:0] MainOnes   = {MainW{1'b1}};

  localparam logic BoolMode  = 1'b1;
  localparam logic ArithMode = 1'b0;

  localparam logic [CarryW-1:0] CC_CIN  = CarryW'(1 << sa38_pkg::CcAdxCin);
  localparam logic [CarryW-1:0] CC_LONG = CarryW'(1 << sa38_pkg::CcLong);
  localparam logic [CarryW-1:0] CC_INH  = CarryW'(1 << sa38_pkg::CcInh18);
  localparam logic [CarryW-1:0] CC_GEN  = CarryW'(1 << sa38_pkg::CcGen18);
  localparam logic [CarryW-1:0] CC_NONE = '0;
  localparam logic [ASelW-1:0]  ASEL_ZERO = ASelW'(1 << sa38_pkg::ASelZeroBit);

  typedef struct {
    sa38_pkg::operand_t stim;
    bit                 typed;
    sa38_pkg::result_t  want;
  } vector_t;

  logic clk;
  logic rst;

  sa38_operand_if operands ();
  sa38_result_if  results ();

  split_adder_alu_38_bit_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .results  (results)
  );

  sa38_pkg::result_t expected_results [$];
  vector_t dir_tab [$];
  int      errors;
  int      cycle_count;
  bit      no_idle;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int idle_cycles();
    return no_idle ? 0 : int'($urandom_range(0, MaxIdle));
  endfunction

  function automatic logic [WordW-1:0] corner_word(int k);
    case (k % 4)
      0:       return '0;
      1:       return WordOnes;
      2:       return WordSign;
      default: return WordMaxPos;
    endcase
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    if ($urandom_range(0, 3) == 0)
      return corner_word(int'($urandom_range(0, 3)));
    return {4'($urandom), $urandom};
  endfunction

  function automatic sa38_pkg::operand_t operands_of(
    logic [WordW-1:0] ar, logic [WordW-1:0] arx, logic [WordW-1:0] br,
    logic [WordW-1:0] brx, logic [WordW-1:0] mq, logic [WordW-1:0] fm,
    logic [AddrW-1:0] hpc, logic [FuncW-1:0] fn, logic [ASelW-1:0] asel,
    logic [BSelW-1:0] bsel, logic [CarryW-1:0] cc);
    sa38_pkg::operand_t s;
    s.acc_word      = ar;
    s.acc_ext_word  = arx;
    s.buf_word      = br;
    s.buf_ext_word  = brx;
    s.quotient_word = mq;
    s.fast_reg_word = fm;
    s.held_or_pc    = hpc;
    s.func          = fn;
    s.a_source      = asel;
    s.b_source      = bsel;
    s.carry_ctl     = cc;
    return s;
  endfunction

  function automatic sa38_pkg::result_t result_of(logic [MainW-1:0] main,
                                                  logic [WordW-1:0] low, logic cm2,
                                                  logic c1, logic ovf, logic lc);
    sa38_pkg::result_t r;
    r.main_sum        = main;
    r.low_sum         = low;
    r.carry_minus_two = cm2;
    r.carry_one       = c1;
    r.overflow_flag   = ovf;
    r.low_carry_out   = lc;
    return r;
  endfunction

  function automatic logic [63:0] sign_extend38(logic [WordW-1:0] w);
    return {26'd0, {2{w[WordW-1]}}, w};
  endfunction

  function automatic logic [63:0] logic_result(sa38_pkg::op_t op, logic [63:0] a,
                                               logic [63:0] b, logic [63:0] m);
    logic [63:0] na;
    logic [63:0] nb;
    na = ~a & m;
    nb = ~b & m;
    case (op)
      sa38_pkg::OP_NOT_A:    return na;
      sa38_pkg::OP_NAND:     return na | nb;
      sa38_pkg::OP_NA_OR_B:  return na | b;
      sa38_pkg::OP_ONES:     return m;
      sa38_pkg::OP_NOR:      return na & nb;
      sa38_pkg::OP_NOT_B:    return nb;
      sa38_pkg::OP_XNOR:     return a ^ nb;
      sa38_pkg::OP_A_OR_NB:  return a | nb;
      sa38_pkg::OP_NA_AND_B: return na & b;
      sa38_pkg::OP_XOR:      return a ^ b;
      sa38_pkg::OP_B:        return b;
      sa38_pkg::OP_OR:       return a | b;
      sa38_pkg::OP_ZERO:     return 64'd0;
      sa38_pkg::OP_A_AND_NB: return a & nb;
      sa38_pkg::OP_AND:      return a & b;
      default:               return a;
    endcase
  endfunction

  // the two addends that the arithmetic mode sums, plus carry in
  function automatic void sum_terms(sa38_pkg::op_t op, logic [63:0] a, logic [63:0] b,
                                    logic [63:0] m,
                                    output logic [63:0] x, output logic [63:0] y);
    logic [63:0] nb;
    nb = ~b & m;
    case (op)
      sa38_pkg::OP_NOT_A:    begin x = a;      y = 64'd0;  end
      sa38_pkg::OP_NAND:     begin x = a;      y = a & nb; end
      sa38_pkg::OP_NA_OR_B:  begin x = a;      y = a & b;  end
      sa38_pkg::OP_ONES:     begin x = a;      y = a;      end
      sa38_pkg::OP_NOR:      begin x = a | b;  y = 64'd0;  end
      sa38_pkg::OP_NOT_B:    begin x = a | b;  y = a & nb; end
      sa38_pkg::OP_XNOR:     begin x = a;      y = b;      end
      sa38_pkg::OP_A_OR_NB:  begin x = a;      y = a | b;  end
      sa38_pkg::OP_NA_AND_B: begin x = a | nb; y = 64'd0;  end
      sa38_pkg::OP_XOR:      begin x = a;      y = nb;     end
      sa38_pkg::OP_B:        begin x = a | b;  y = a & b;  end
      sa38_pkg::OP_OR:       begin x = a;      y = a | nb; end
      sa38_pkg::OP_ZERO:     begin x = 64'd0;  y = m;      end
      sa38_pkg::OP_A_AND_NB: begin x = a & nb; y = m;      end
      sa38_pkg::OP_AND:      begin x = a & b;  y = m;      end
      default:               begin x = a;      y = m;      end
    endcase
  endfunction

  function automatic sa38_pkg::result_t predict_alu(sa38_pkg::operand_t s);
    sa38_pkg::op_t     op;
    logic              boolean;
    logic [63:0]       la;
    logic [63:0]       lb;
    logic [63:0]       lsum;
    logic [63:0]       ma;
    logic [63:0]       mb;
    logic [63:0]       msum;
    logic [63:0]       x;
    logic [63:0]       y;
    logic [63:0]       cin;
    sa38_pkg::result_t r;
    op      = sa38_pkg::op_t'(s.func[3:0]);
    boolean = s.func[sa38_pkg::FuncBoolBit];

    la = s.a_source[sa38_pkg::ASelZeroBit] ? 64'd0 : 64'(s.acc_ext_word);
    case (s.b_source)
      sa38_pkg::BSEL_FAST:   lb = Ones36;
      sa38_pkg::BSEL_BR_SH1: lb = (64'(s.buf_ext_word) << 1) & Ones36;
      sa38_pkg::BSEL_BR:     lb = 64'(s.buf_ext_word);
      default:               lb = (64'(s.acc_ext_word) << 2) & Ones36;
    endcase
    if (boolean) begin
      lsum = logic_result(op, la, lb, Ones36);
    end else begin
      sum_terms(op, la, lb, Ones36, x, y);
      lsum = x + y + 64'(s.carry_ctl[sa38_pkg::CcAdxCin]);
    end

    case (s.a_source)
      sa38_pkg::ASEL_AR:   ma = sign_extend38(s.acc_word);
      sa38_pkg::ASEL_ARX:  ma = sign_extend38(s.acc_ext_word);
      sa38_pkg::ASEL_MQ:   ma = sign_extend38(s.quotient_word);
      sa38_pkg::ASEL_HELD: ma = 64'(s.held_or_pc);
      default:             ma = 64'd0;
    endcase
    case (s.b_source)
      sa38_pkg::BSEL_FAST:   mb = sign_extend38(s.fast_reg_word);
      sa38_pkg::BSEL_BR_SH1: mb = (sign_extend38(s.buf_word) << 1) | 64'(s.buf_ext_word[35]);
      sa38_pkg::BSEL_BR:     mb = sign_extend38(s.buf_word);
      default:               mb = (sign_extend38(s.acc_word) << 2)
                                  | 64'(s.acc_ext_word[35:34]);
    endcase
    mb &= Ones38;

    if (boolean) begin
      msum = logic_result(op, ma, mb, Ones38);
    end else begin
      cin = 64'(lsum[36] & s.carry_ctl[sa38_pkg::CcLong]);
      sum_terms(op, ma, mb, Ones38, x, y);
      // with inhibit, the upper 20 bits never see the carry from bit 17
      if (s.carry_ctl[sa38_pkg::CcInh18])
        msum = ((x & Upper20) + (y & Upper20)) | ((x + y + cin) & Low18);
      else
        msum = x + y + cin;
      if (s.carry_ctl[sa38_pkg::CcGen18])
        msum += Carry18;
    end

    r.main_sum        = msum[MainW-1:0];
    r.low_sum         = lsum[WordW-1:0];
    r.carry_minus_two = msum[38];
    r.carry_one       = sa38_pkg::Cry1Table[msum[38:35]];
    r.overflow_flag   = sa38_pkg::OvfTable[msum[37:35]];
    r.low_carry_out   = lsum[36];
    return r;
  endfunction

  task automatic push_operands(input sa38_pkg::operand_t item, input bit typed,
                               input sa38_pkg::result_t want);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      operands.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operands.acc_word      <= item.acc_word;
    operands.acc_ext_word  <= item.acc_ext_word;
    operands.buf_word      <= item.buf_word;
    operands.buf_ext_word  <= item.buf_ext_word;
    operands.quotient_word <= item.quotient_word;
    operands.fast_reg_word <= item.fast_reg_word;
    operands.held_or_pc    <= item.held_or_pc;
    operands.func          <= item.func;
    operands.a_source      <= item.a_source;
    operands.b_source      <= item.b_source;
    operands.carry_ctl     <= item.carry_ctl;
    operands.valid         <= 1'b1;
    do @(posedge clk); while (!operands.ready);
    expected_results.push_back(typed ? want : predict_alu(item));
    @(negedge clk);
  endtask

  task automatic drain_results();
    int                stall;
    sa38_pkg::result_t got;
    sa38_pkg::result_t want;
    bit                bad;
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        results.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!results.valid);
      got = result_of(results.main_sum, results.low_sum, results.carry_minus_two,
                      results.carry_one, results.overflow_flag, results.low_carry_out);
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result transfer with nothing pending: %h", got);
      end else begin
        want = expected_results.pop_front();
        bad = (got.main_sum !== want.main_sum) || (got.low_sum !== want.low_sum) ||
              (got.carry_minus_two !== want.carry_minus_two) ||
              (got.carry_one !== want.carry_one) ||
              (got.overflow_flag !== want.overflow_flag) ||
              (got.low_carry_out !== want.low_carry_out);
        if (bad) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: main %h/%h low %h/%h cm2 %b/%b cry1 %b/%b ovf %b/%b lcry %b/%b",
                     want.main_sum, got.main_sum, want.low_sum, got.low_sum,
                     want.carry_minus_two, got.carry_minus_two, want.carry_one,
                     got.carry_one, want.overflow_flag, got.overflow_flag,
                     want.low_carry_out, got.low_carry_out);
        end
      end
      @(negedge clk);
    end
  endtask

  initial begin
    vector_t            row;
    sa38_pkg::operand_t item;
    sa38_pkg::result_t  none;
    none = '0;

    rst = 1'b1;
    errors = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    results.ready = 1'b0;
    operands.valid = 1'b0;
    operands.acc_word = '0;
    operands.acc_ext_word = '0;
    operands.buf_word = '0;
    operands.buf_ext_word = '0;
    operands.quotient_word = '0;
    operands.fast_reg_word = '0;
    operands.held_or_pc = '0;
    operands.func = '0;
    operands.a_source = '0;
    operands.b_source = '0;
    operands.carry_ctl = '0;

    // rows with an obvious answer carry it; the rest go through the predictor
    row.typed = 1'b1;
    row.stim = operands_of('0, '0, '0, '0, '0, '0, '0, {BoolMode, sa38_pkg::OP_ZERO},
                           sa38_pkg::ASEL_AR, sa38_pkg::BSEL_FAST, CC_NONE);
    row.want = result_of('0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
    dir_tab.push_back(row);
    // boolean mode ignores every carry control
    row.stim = operands_of(WordOnes, WordOnes, WordOnes, WordOnes, WordOnes, WordOnes,
                           {AddrW{1'b1}}, {BoolMode, sa38_pkg::OP_ONES},
                           sa38_pkg::ASEL_AR, sa38_pkg::BSEL_FAST,
                           CC_CIN | CC_LONG | CC_INH | CC_GEN);
    row.want = result_of(MainOnes, WordOnes, 1'b0, 1'b0, 1'b0, 1'b0);
    dir_tab.push_back(row);
    // low carry rippling through the long chain out of the top of AD
    row.stim = operands_of('0, '0, '0, '0, '0, '0, '0, {ArithMode, sa38_pkg::OP_ZERO},
                           ASEL_ZERO, sa38_pkg::BSEL_FAST, CC_CIN | CC_LONG);
    row.want = result_of('0, '0, 1'b1, 1'b1, 1'b0, 1'b1);
    dir_tab.push_back(row);
    row.stim = operands_of('0, '0, '0, '0, '0, '0, '0, {ArithMode, sa38_pkg::OP_ZERO},
                           ASEL_ZERO, sa38_pkg::BSEL_FAST, CC_NONE);
    row.want = result_of(MainOnes, WordOnes, 1'b0, 1'b0, 1'b0, 1'b0);
    dir_tab.push_back(row);
    // bit 18 carry: plain, inhibited, inhibited and forced, forced alone
    row.stim = operands_of('0, WordOnes, '0, '0, '0, '0, 23'o777777,
                           {ArithMode, sa38_pkg::OP_NOT_A},
                           sa38_pkg::ASEL_HELD, sa38_pkg::BSEL_FAST, CC_CIN | CC_LONG);
    row.want = result_of(38'o1000000, '0, 1'b0, 1'b0, 1'b0, 1'b1);
    dir_tab.push_back(row);
    row.stim.carry_ctl = CC_CIN | CC_LONG | CC_INH;
    row.want = result_of('0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
    dir_tab.push_back(row);
    row.stim.carry_ctl = CC_CIN | CC_LONG | CC_INH | CC_GEN;
    row.want = result_of(38'o1000000, '0, 1'b0, 1'b0, 1'b0, 1'b1);
    dir_tab.push_back(row);
    row.stim.carry_ctl = CC_GEN;
    row.want = result_of(38'o1777777, WordOnes, 1'b0, 1'b0, 1'b0, 1'b0);
    dir_tab.push_back(row);
    // positive overflow into bit 35
    row.stim = operands_of(WordMaxPos, '0, '0, '0, '0, 36'd1, '0,
                           {ArithMode, sa38_pkg::OP_XNOR},
                           sa38_pkg::ASEL_AR, sa38_pkg::BSEL_FAST, CC_NONE);
    row.want = result_of(38'o0400000000000, WordOnes, 1'b0, 1'b1, 1'b1, 1'b0);
    dir_tab.push_back(row);

    row.typed = 1'b0;
    row.want = none;
    row.stim = operands_of(WordSign, '0, '0, '0, '0, WordSign, '0,
                           {ArithMode, sa38_pkg::OP_XNOR},
                           sa38_pkg::ASEL_AR, sa38_pkg::BSEL_FAST, CC_NONE);
    dir_tab.push_back(row);
    for (int k = 0; k < 16; k++) begin
      row.stim = operands_of(corner_word(k), corner_word(k + 1), corner_word(k + 2),
                             corner_word(k + 3), corner_word(k / 2), corner_word(k / 4),
                             k[0] ? {AddrW{1'b1}} : '0, {k[0], 4'(k)}, ASelW'(k),
                             BSelW'(k), CarryW'(k));
      dir_tab.push_back(row);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    foreach (dir_tab[i])
      push_operands(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);

    for (int n = 0; n < OperandCount; n++) begin
      if (n % 64 == 0)
        no_idle = ($urandom_range(0, 3) == 0);
      item = operands_of(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                         pick_word(),
                         ($urandom_range(0, 3) == 0) ? {AddrW{1'b1}} : AddrW'($urandom),
                         FuncW'($urandom), ASelW'($urandom), BSelW'($urandom),
                         CarryW'($urandom));
      push_operands(item, 1'b0, none);
    end
    operands.valid <= 1'b0;

    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
